FILE: hw/rtl/ps2fr_pkg.sv
// ----------------------------------------------------------------------------
// ps2fr_pkg
// shared types, codes and constants of the ps/2 frame receiver with ring buffer
// ----------------------------------------------------------------------------
`default_nettype none

package ps2fr_pkg;

	localparam int BUFFER_DEPTH = 16;
	localparam int EMPTY_VALUE  = 255;
	localparam int SLOT_W       = $clog2(BUFFER_DEPTH);
	localparam int READ_SLOT_W  = 4;
	localparam int READ_SLOTS   = 1 << READ_SLOT_W;

	localparam logic [7:0] EMPTY_BYTE = 8'(EMPTY_VALUE);

	// bit position codes of the deframer
	localparam logic [3:0] POS_IDLE      = 4'd0;
	localparam logic [3:0] POS_LAST_DATA = 4'd8;
	localparam logic [3:0] POS_PARITY    = 4'd9;
	localparam logic [3:0] POS_STOP      = 4'd10;

	typedef enum logic {
		CMD_EDGE = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_READ = 1'b1
	} kind_t;

	typedef logic [SLOT_W-1:0] slot_idx_t;

	// finished frame handed from the deframer to the ring
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} frame_t;

	// read slot field folded onto the ring depth
	typedef logic [READ_SLOTS-1:0][SLOT_W-1:0] slot_lut_t;

	function automatic slot_lut_t build_slot_lut();
		slot_lut_t lut;
		for (int i = 0; i < READ_SLOTS; i++) begin
			lut[i] = SLOT_W'(i % BUFFER_DEPTH);
		end
		return lut;
	endfunction

	localparam slot_lut_t SLOT_LUT = build_slot_lut();

endpackage

`default_nettype wire

FILE: hw/rtl/ps2fr_req_if.sv
// ----------------------------------------------------------------------------
// ps2fr_req_if
// request channel: keyboard clock edge with data bit, or buffer slot read
// ----------------------------------------------------------------------------
`default_nettype none

interface ps2fr_req_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic       data_bit;
	logic [3:0] read_slot;

	modport source (output valid, output cmd, output data_bit, output read_slot, input ready);
	modport sink   (input valid, input cmd, input data_bit, input read_slot, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ps2fr_res_if.sv
// ----------------------------------------------------------------------------
// ps2fr_res_if
// result channel: received byte or read data with its slot
// ----------------------------------------------------------------------------
`default_nettype none

interface ps2fr_res_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] value;
	logic [3:0] slot;

	modport source (output valid, output kind, output value, output slot, input ready);
	modport sink   (input valid, input kind, input value, input slot, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ps2fr_deframer.sv
// ----------------------------------------------------------------------------
// ps2fr_deframer
// start / data / parity / stop bit tracking of one at-ps/2 frame
// ----------------------------------------------------------------------------
`default_nettype none

module ps2fr_deframer
	import ps2fr_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   fire,
	input  wire logic   data_bit,
	output frame_t      frame
);

	logic [3:0] bit_pos_q, bit_pos_nxt;
	logic [7:0] shift_q, shift_nxt;
	logic       parity_q, parity_nxt;

	always_comb begin
		bit_pos_nxt = bit_pos_q;
		shift_nxt   = shift_q;
		parity_nxt  = parity_q;
		frame.valid = 1'b0;
		frame.data  = shift_q;
		if (bit_pos_q == POS_IDLE || bit_pos_q > POS_STOP) begin
			// low start bit opens a frame
			parity_nxt  = 1'b0;
			bit_pos_nxt = data_bit ? POS_IDLE : 4'd1;
		end else if (bit_pos_q <= POS_LAST_DATA) begin
			shift_nxt   = {data_bit, shift_q[7:1]};
			parity_nxt  = parity_q ^ data_bit;
			bit_pos_nxt = bit_pos_q + 4'd1;
		end else if (bit_pos_q == POS_PARITY) begin
			parity_nxt  = parity_q ^ data_bit;
			bit_pos_nxt = POS_STOP;
		end else begin
			bit_pos_nxt = POS_IDLE;
			frame.valid = data_bit & parity_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_pos_q <= POS_IDLE;
			shift_q   <= '0;
			parity_q  <= 1'b0;
		end else if (fire) begin
			bit_pos_q <= bit_pos_nxt;
			shift_q   <= shift_nxt;
			parity_q  <= parity_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ps2fr_ring.sv
// ----------------------------------------------------------------------------
// ps2fr_ring
// ring buffer of received bytes with one read port and a write pointer
// ----------------------------------------------------------------------------
`default_nettype none

module ps2fr_ring
	import ps2fr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [7:0]       wr_data,
	input  wire logic [3:0]       rd_slot,
	output slot_idx_t             rd_index,
	output logic [7:0]            rd_data,
	output slot_idx_t             wr_index
);

	logic [7:0]              ring_q [BUFFER_DEPTH];
	logic [BUFFER_DEPTH-1:0] used_q;
	slot_idx_t               wr_slot_q;

	// next slot after the last one written
	assign wr_index = (wr_slot_q == SLOT_W'(BUFFER_DEPTH - 1)) ? '0 : wr_slot_q + 1'b1;

	assign rd_index = SLOT_LUT[rd_slot];
	assign rd_data  = used_q[rd_index] ? ring_q[rd_index] : EMPTY_BYTE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			wr_slot_q <= SLOT_W'(BUFFER_DEPTH - 1);
		end else if (wr_en) begin
			used_q[wr_index] <= 1'b1;
			wr_slot_q        <= wr_index;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_q[wr_index] <= wr_data;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ps2_frame_receiver_ring.sv
// ----------------------------------------------------------------------------
// ps2_frame_receiver_ring
// at-ps/2 keyboard frame receiver feeding a ring buffer of received bytes
// ----------------------------------------------------------------------------
//
//  channel   dir  fields                          what it moves
//  request   in   cmd, data_bit, read_slot        clock edge with data bit, or slot read
//  result    out  kind, value, slot               received byte, or read data
//
//  one request per cycle while the input register is not stalled; a request is
//  held in the input register, is worked there against the deframer state and
//  the ring, and its result (if any) lands in the output register as it moves on
//  reset clears the deframer, the ring used bits and the write pointer at once
//  an output stall holds the input register only when its request has a result;
//  edges that end in no result keep moving while a result waits
//
`default_nettype none

module ps2_frame_receiver_ring
	import ps2fr_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	ps2fr_req_if.sink     request,
	ps2fr_res_if.source   result
);

	// input register
	logic       valid_s1;
	logic       cmd_s1;
	logic       data_bit_s1;
	logic [3:0] read_slot_s1;

	// output register
	logic       out_valid_q;
	logic       out_kind_q;
	logic [7:0] out_value_q;
	logic [3:0] out_slot_q;

	frame_t     frame;
	slot_idx_t  rd_index;
	slot_idx_t  wr_index;
	logic [7:0] rd_data;

	logic is_read;
	logic has_result;
	logic out_free;
	logic s1_adv;
	logic edge_fire;

	assign is_read    = (cmd_s1 == CMD_READ);
	assign has_result = is_read | frame.valid;
	assign out_free   = !out_valid_q | result.ready;
	// an edge with no result never waits on the output side
	assign s1_adv     = valid_s1 & (!has_result | out_free);
	assign edge_fire  = s1_adv & !is_read;

	assign request.ready = !valid_s1 | s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.ready && request.valid) begin
			cmd_s1       <= request.cmd;
			data_bit_s1  <= request.data_bit;
			read_slot_s1 <= request.read_slot;
		end
	end

	ps2fr_deframer u_deframer (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (edge_fire),
		.data_bit (data_bit_s1),
		.frame    (frame)
	);

	ps2fr_ring u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (edge_fire & frame.valid),
		.wr_data  (frame.data),
		.rd_slot  (read_slot_s1),
		.rd_index (rd_index),
		.rd_data  (rd_data),
		.wr_index (wr_index)
	);

	// result register, loaded when the request in s1 has a result and moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && has_result) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && has_result) begin
			if (is_read) begin
				out_kind_q  <= KIND_READ;
				out_value_q <= rd_data;
				out_slot_q  <= 4'(rd_index);
			end else begin
				out_kind_q  <= KIND_BYTE;
				out_value_q <= frame.data;
				out_slot_q  <= 4'(wr_index);
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.kind  = out_kind_q;
	assign result.value = out_value_q;
	assign result.slot  = out_slot_q;

	// a stalled request stays put in the input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(cmd_s1) && $stable(read_slot_s1))
		else $error("input register lost a stalled request");

	// the input side only stalls behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!request.ready |-> valid_s1 && out_valid_q && !result.ready)
		else $error("request stalled with no result waiting");

	// a read that moves on always shows up as read data
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && is_read |=> out_valid_q && out_kind_q == KIND_READ)
		else $error("read request produced no read result");

endmodule

`default_nettype wire
